>>> rtl/core/bfr_pkg.sv
// Package for the byte ring FIFO: sizes, action codes and the command
// record that travels from the front end through the queue to the back end.
// No dependencies.
package bfr_pkg;

    // Ring storage: DEPTH bytes, pointers one bit wider than the address
    localparam int ADDR_W = 10;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int PTR_W  = ADDR_W + 1;

    // Longest burst and the width that holds 0..MAX_BURST
    localparam int MAX_BURST = 64;
    localparam int LEN_W     = $clog2(MAX_BURST + 1);
    localparam int OFF_W     = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

    // Configuration register
    localparam int          CFG_W     = 4;
    localparam logic [3:0]  CAP_RESET = 4'd10;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);

    // Input action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_PEEK  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Work the back end performs for one item
    typedef enum logic [1:0] {
        CMD_SINGLE = 2'd0,   // one status-only result
        CMD_WRITE  = 2'd1,   // store a byte, one status result
        CMD_BURST  = 2'd2    // read count bytes from the ring
    } t_kind;

    // Status reported on every result of an item
    typedef struct packed {
        logic             accepted;
        logic [PTR_W-1:0] fill;
        logic [PTR_W-1:0] free;
        logic             empty;
        logic             full;
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] amask;
        logic [7:0]        data;
        logic [LEN_W-1:0]  count;
        t_status           status;
    } t_cmd;

endpackage

>>> rtl/core/bfr_front.sv
// Front end of the byte ring FIFO: accepts items, keeps the capacity register
// and both ring pointers, and turns each item into one back-end command.
// Depends on bfr_pkg.
module bfr_front import bfr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_data_in,
    input  logic [LEN_W-1:0] i_burst_length,
    input  logic             i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [CFG_W-1:0]  r_cap_log2;
    logic [PTR_W-1:0]  r_wr_pos, n_wr_pos;
    logic [PTR_W-1:0]  r_rd_pos, n_rd_pos;

    logic [CFG_W-1:0]  cap_k;
    logic [PTR_W-1:0]  cap;
    logic [ADDR_W-1:0] amask;
    logic [PTR_W-1:0]  fill_now;
    logic [PTR_W-1:0]  fill_after;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  burst_n;
    logic              room;
    logic              accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    // Saturate the capacity to the ring size
    assign cap_k = (r_cap_log2 > CFG_W'(ADDR_W)) ? CFG_W'(ADDR_W) : r_cap_log2;
    assign cap   = PTR_W'(1) << cap_k;
    assign amask = ADDR_W'(cap - PTR_W'(1));

    assign fill_now = r_wr_pos - r_rd_pos;
    assign room     = fill_now < cap;

    // Clip the request to the burst limit and then to the fill
    assign len_sat = (i_burst_length > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST)
                                                          : i_burst_length;
    assign burst_n = ({{(PTR_W-LEN_W){1'b0}}, len_sat} < fill_now) ? len_sat
                                                                  : fill_now[LEN_W-1:0];

    // Next pointers for this item
    always_comb begin
        n_wr_pos = r_wr_pos;
        n_rd_pos = r_rd_pos;
        unique case (i_action) inside
            ACT_WRITE: begin
                if (room) n_wr_pos = r_wr_pos + PTR_W'(1);
            end
            ACT_READ: begin
                n_rd_pos = r_rd_pos + PTR_W'(burst_n);
            end
            ACT_PEEK: begin
                n_rd_pos = r_rd_pos;
            end
            ACT_CLEAR: begin
                n_wr_pos = '0;
                n_rd_pos = '0;
            end
            default: begin
                n_wr_pos = r_wr_pos;
            end
        endcase
    end

    assign fill_after = n_wr_pos - n_rd_pos;

    // Build the command for the back end
    always_comb begin
        o_cmd.kind            = CMD_SINGLE;
        o_cmd.addr            = r_rd_pos[ADDR_W-1:0] & amask;
        o_cmd.amask           = amask;
        o_cmd.data            = i_data_in;
        o_cmd.count           = burst_n;
        o_cmd.status.accepted = 1'b0;
        o_cmd.status.fill     = fill_after;
        o_cmd.status.free     = (fill_after >= cap) ? '0 : cap - fill_after;
        o_cmd.status.empty    = (n_wr_pos == n_rd_pos);
        o_cmd.status.full     = (fill_after == cap);
        unique case (i_action) inside
            ACT_WRITE: begin
                o_cmd.addr            = r_wr_pos[ADDR_W-1:0] & amask;
                o_cmd.status.accepted = room;
                if (room) o_cmd.kind = CMD_WRITE;
            end
            ACT_READ, ACT_PEEK: begin
                if (burst_n != '0) o_cmd.kind = CMD_BURST;
            end
            default: begin
                o_cmd.kind = CMD_SINGLE;
            end
        endcase
    end

    // Hold the capacity register; advance pointers on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_log2 <= CAP_RESET;
            r_wr_pos   <= '0;
            r_rd_pos   <= '0;
        end else begin
            if (i_cfg_wr_en) r_cap_log2 <= i_cfg_wr_data;
            if (accept) begin
                r_wr_pos <= n_wr_pos;
                r_rd_pos <= n_rd_pos;
            end
        end
    end

    // Writes only land below capacity, so the fill never passes the ring size
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_now <= PTR_W'(DEPTH))
        else $error("ring fill exceeds ring size");

endmodule

>>> rtl/core/bfr_cmd_queue.sv
// Short command queue between the front and back ends of the byte ring FIFO.
// Flip-flop storage, one push and one pop per cycle. Depends on bfr_pkg.
module bfr_cmd_queue import bfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd            r_slot [QDEPTH];
    logic [QA_W:0]   r_wp;
    logic [QA_W:0]   r_rp;

    assign o_valid = (r_wp != r_rp);
    assign o_full  = (r_wp[QA_W-1:0] == r_rp[QA_W-1:0]) && (r_wp[QA_W] != r_rp[QA_W]);
    assign o_cmd   = r_slot[r_rp[QA_W-1:0]];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp[QA_W-1:0]] <= i_cmd;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + (QA_W+1)'(1);
            if (i_pop)  r_rp <= r_rp + (QA_W+1)'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("command popped from empty queue");

endmodule

>>> rtl/core/bfr_back.sv
// Back end of the byte ring FIFO: owns the ring memory, executes queued
// commands one step per cycle while the output register is free or being read, and holds the output register.
// Depends on bfr_pkg.
module bfr_back import bfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_data_out,
    output logic              o_byte_valid,
    output logic              o_last,
    output logic              o_accepted,
    output logic [PTR_W-1:0]  o_fill_level,
    output logic [PTR_W-1:0]  o_free_space,
    output logic              o_is_empty,
    output logic              o_is_full
);

    logic [7:0]        r_ring [DEPTH];
    logic [7:0]        r_rd_data;
    logic [OFF_W-1:0]  r_off;
    logic              r_out_valid;
    logic              r_byte_valid;
    logic              r_last;
    t_status           r_status;

    logic              advance;
    logic              step_last;
    logic [ADDR_W-1:0] rd_addr;

    assign advance   = i_q_valid && (!r_out_valid || i_out_ready);
    assign step_last = (i_cmd.kind != CMD_BURST) ||
                       ((LEN_W'(r_off) + LEN_W'(1)) == i_cmd.count);
    assign o_pop     = advance && step_last;
    assign rd_addr   = (i_cmd.addr + ADDR_W'(r_off)) & i_cmd.amask;

    // Ring memory: one write or one registered read per step
    always_ff @(posedge i_clk) begin
        if (advance && i_cmd.kind == CMD_WRITE) r_ring[i_cmd.addr] <= i_cmd.data;
        if (advance && i_cmd.kind == CMD_BURST) r_rd_data <= r_ring[rd_addr];
    end

    // Step through a burst; restart at zero for the next command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
        end else if (advance) begin
            r_off <= step_last ? '0 : r_off + OFF_W'(1);
        end
    end

    // Output register: load on each step, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte_valid <= (i_cmd.kind == CMD_BURST);
            r_last       <= step_last;
            r_status     <= i_cmd.status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_byte_valid ? r_rd_data : 8'd0;
    assign o_byte_valid = r_byte_valid;
    assign o_last       = r_last;
    assign o_accepted   = r_status.accepted;
    assign o_fill_level = r_status.fill;
    assign o_free_space = r_status.free;
    assign o_is_empty   = r_status.empty;
    assign o_is_full    = r_status.full;

    a_off_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && i_cmd.kind != CMD_BURST) |-> (r_off == '0))
        else $error("burst offset left over on a non-burst command");

    a_mid_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> r_byte_valid)
        else $error("non-final result without a byte");

    a_byte_not_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_byte_valid) |-> !r_status.accepted)
        else $error("byte result flagged as accepted write");

endmodule

>>> rtl/core/byte_ring_fifo.sv
// Top level of the byte ring FIFO: front end, command queue and back end.
// Depends on bfr_pkg, bfr_front, bfr_cmd_queue and bfr_back.
//
// A byte FIFO in a 1024-byte ring whose usable capacity is 2^capacity_log2
// bytes (values above 10 act as 10; write clear after changing it). The
// front end takes one item per cycle while its four-entry command queue has
// room and settles pointers and status at once; the back end then gives a
// single result for a write, a clear or an empty request and one result per
// byte of a read or peek burst, one byte per cycle while the output is taken,
// from the ring's single read port. A result passes through the command queue
// and then the output register, and transfers when i_out_ready is high. Ring
// contents are undefined until written and need no clearing after reset.
module byte_ring_fifo import bfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_data_in,
    input  logic [LEN_W-1:0]  i_burst_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_data_out,
    output logic              o_byte_valid,
    output logic              o_last,
    output logic              o_accepted,
    output logic [PTR_W-1:0]  o_fill_level,
    output logic [PTR_W-1:0]  o_free_space,
    output logic              o_is_empty,
    output logic              o_is_full
);

    logic q_full;
    logic push;
    logic pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Accept and classify items
    bfr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_data_in      (i_data_in),
        .i_burst_length (i_burst_length),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Decouple front from back
    bfr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Execute commands against the ring
    bfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data_out   (o_data_out),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_accepted   (o_accepted),
        .o_fill_level (o_fill_level),
        .o_free_space (o_free_space),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

endmodule
